@@ rtl/priority_run_queue_with_aging_assert.svh @@
// Assertion macros for the priority run queue.
// Used by the top level; needs no other file.
`ifndef PRIORITY_RUN_QUEUE_WITH_AGING_ASSERT_SVH
`define PRIORITY_RUN_QUEUE_WITH_AGING_ASSERT_SVH

// same-cycle implication
`define PRQA_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define PRQA_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/prqa_pkg.sv @@
// Shared types and constants of the priority run queue.
// Used by the controller, the datapath and the top level.
package prqa_pkg;

    localparam int MAX_TASKS_DEF  = 64;
    localparam int NUM_LEVELS_DEF = 5;

    localparam int CMD_W   = 2;
    localparam int TID_W   = 6;
    localparam int PRIO_W  = 3;
    localparam int TIME_W  = 48;
    localparam int LVLO_W  = 3;
    localparam int TOTAL_W = 7;

    localparam int TID_LSB  = 0;
    localparam int PRIO_LSB = TID_LSB + TID_W;
    localparam int TIME_LSB = PRIO_LSB + PRIO_W;

    localparam int S_DATA_W = 64;
    localparam int M_DATA_W = 24;

    localparam logic [TIME_W-1:0] AGING_RESET = 48'd4000000000;

    typedef enum logic [CMD_W-1:0] {
        CMD_ENQ  = 2'd0,
        CMD_DEQ  = 2'd1,
        CMD_PICK = 2'd2,
        CMD_TICK = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_APPEND,
        ST_RESP
    } state_t;

    typedef struct packed {
        logic load;
        logic exec;
        logic append;
        logic resp;
    } ctrl_cmd_t;

    typedef struct packed {
        logic age;
        logic out_free;
    } dp_stat_t;

    // status in the lowest bit
    typedef struct packed {
        logic [TOTAL_W-1:0] total_queued;
        logic               resched;
        logic [LVLO_W-1:0]  level_out;
        logic               pick_valid;
        logic [TID_W-1:0]   picked_task;
        logic               status;
    } result_t;

endpackage

@@ rtl/prqa_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module prqa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                             aclk,
    input  logic                             we,
    input  logic [$clog2(DEPTH)-1:0]         waddr,
    input  logic [WIDTH-1:0]                 wdata,
    input  logic [$clog2(DEPTH)-1:0]         raddr,
    output logic [WIDTH-1:0]                 rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

@@ rtl/prqa_ctrl.sv @@
// Sequencer of the priority run queue: accept, execute, aging append, respond.
// Depends on prqa_pkg.
module prqa_ctrl import prqa_pkg::*; (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_tvalid,
    output logic      s_tready,
    input  dp_stat_t  stat,
    output ctrl_cmd_t ctrl
);

    state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC: begin
                state_next = stat.age ? ST_APPEND : ST_RESP;
            end
            ST_APPEND: begin
                state_next = ST_RESP;
            end
            ST_RESP: begin
                if (stat.out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        s_tready    = 1'b0;
        ctrl        = '0;
        case (state_reg)
            ST_IDLE: begin
                s_tready  = 1'b1;
                ctrl.load = s_tvalid;
            end
            ST_EXEC: begin
                ctrl.exec = 1'b1;
            end
            ST_APPEND: begin
                ctrl.append = 1'b1;
            end
            ST_RESP: begin
                ctrl.resp = 1'b1;
            end
            default: begin
                ctrl = '0;
            end
        endcase
    end

endmodule

@@ rtl/prqa_dp.sv @@
// Datapath of the priority run queue: per-level lists, link RAMs, result register.
// Depends on prqa_pkg and prqa_ram.
module prqa_dp import prqa_pkg::*; #(
    parameter int MAX_TASKS  = MAX_TASKS_DEF,
    parameter int NUM_LEVELS = NUM_LEVELS_DEF
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  ctrl_cmd_t           ctrl,
    output dp_stat_t            stat,
    input  logic [CMD_W-1:0]    in_cmd,
    input  logic [TID_W-1:0]    in_tid,
    input  logic [PRIO_W-1:0]   in_preq,
    input  logic [TIME_W-1:0]   in_time,
    input  logic                cfg_we,
    input  logic [TIME_W-1:0]   cfg_wdata,
    input  logic                m_tready,
    output logic                m_tvalid,
    output logic [M_DATA_W-1:0] m_tdata
);

    localparam int TASK_W = $clog2(MAX_TASKS);
    localparam int LVL_W  = $clog2(NUM_LEVELS);
    localparam int CNT_W  = $clog2(MAX_TASKS + 1);

    cmd_t               cmd_reg;
    logic [TID_W-1:0]   tid_reg;
    logic [PRIO_W-1:0]  preq_reg;
    logic [TIME_W-1:0]  time_reg;
    logic [TIME_W-1:0]  thr_reg;

    logic [MAX_TASKS-1:0] queued_reg, queued_next;
    logic [TASK_W-1:0]    head_reg  [NUM_LEVELS];
    logic [TASK_W-1:0]    head_next [NUM_LEVELS];
    logic [TASK_W-1:0]    tail_reg  [NUM_LEVELS];
    logic [TASK_W-1:0]    tail_next [NUM_LEVELS];
    logic [CNT_W-1:0]     count_reg [NUM_LEVELS];
    logic [CNT_W-1:0]     count_next[NUM_LEVELS];
    logic [CNT_W-1:0]     total_reg, total_next;

    result_t res_reg, res_next;
    result_t m_data_reg;
    logic    m_valid_reg;

    logic [TASK_W-1:0]     t_idx, rd_addr;
    logic [TASK_W-1:0]     next_rd, prev_rd;
    logic [LVL_W-1:0]      lvl_rd;
    logic                  next_we, prev_we, lvl_we;
    logic [TASK_W-1:0]     next_waddr, next_wdata, prev_waddr, prev_wdata;
    logic [LVL_W-1:0]      lvl_wdata;

    logic                  tid_ok, queued, enq_ok, deq_ok, age, any_ne;
    logic [NUM_LEVELS-1:0] nonempty;
    logic [LVL_W-1:0]      h, lvl_sel;
    logic [TASK_W-1:0]     head_sel, tail_sel;
    logic [CNT_W-1:0]      count_sel;
    logic                  do_append, do_unlink, is_head, is_tail;

    prqa_ram #(.WIDTH(TASK_W), .DEPTH(MAX_TASKS)) u_next_ram (
        .aclk  (aclk),
        .we    (next_we),
        .waddr (next_waddr),
        .wdata (next_wdata),
        .raddr (rd_addr),
        .rdata (next_rd)
    );

    prqa_ram #(.WIDTH(TASK_W), .DEPTH(MAX_TASKS)) u_prev_ram (
        .aclk  (aclk),
        .we    (prev_we),
        .waddr (prev_waddr),
        .wdata (prev_wdata),
        .raddr (rd_addr),
        .rdata (prev_rd)
    );

    prqa_ram #(.WIDTH(LVL_W), .DEPTH(MAX_TASKS)) u_level_ram (
        .aclk  (aclk),
        .we    (lvl_we),
        .waddr (t_idx),
        .wdata (lvl_wdata),
        .raddr (rd_addr),
        .rdata (lvl_rd)
    );

    assign t_idx   = TASK_W'(tid_reg);
    assign rd_addr = ctrl.load ? TASK_W'(in_tid) : t_idx;
    assign tid_ok  = 32'(tid_reg) < MAX_TASKS;
    assign queued  = tid_ok && queued_reg[t_idx];

    always_comb begin
        h = '0;
        for (int i = NUM_LEVELS - 1; i >= 0; i--) begin
            nonempty[i] = (count_reg[i] != '0);
            if (nonempty[i]) begin
                h = LVL_W'(i);
            end
        end
    end

    assign any_ne = |nonempty;

    always_comb begin
        if (ctrl.append) begin
            lvl_sel = '0;
        end else begin
            case (cmd_reg)
                CMD_ENQ:  lvl_sel = LVL_W'(preq_reg);
                CMD_PICK: lvl_sel = h;
                default:  lvl_sel = lvl_rd;
            endcase
        end
    end

    assign head_sel  = head_reg[lvl_sel];
    assign tail_sel  = tail_reg[lvl_sel];
    assign count_sel = count_reg[lvl_sel];
    assign is_head   = (head_sel == t_idx);
    assign is_tail   = (tail_sel == t_idx);

    assign enq_ok = tid_ok && !queued && (32'(preq_reg) < NUM_LEVELS);
    assign deq_ok = queued;
    assign age    = queued && (time_reg > thr_reg) && (lvl_rd > h);

    assign do_append = (ctrl.exec && cmd_reg == CMD_ENQ && enq_ok) || ctrl.append;
    assign do_unlink = ctrl.exec && ((cmd_reg == CMD_DEQ && deq_ok) ||
                                     (cmd_reg == CMD_TICK && age));

    assign stat.age      = (cmd_reg == CMD_TICK) && age;
    assign stat.out_free = !m_valid_reg || m_tready;

    // link RAM writes, list heads/tails, level counts and queued flags/total
    always_comb begin
        next_we     = 1'b0;
        next_waddr  = tail_sel;
        next_wdata  = t_idx;
        prev_we     = 1'b0;
        prev_waddr  = t_idx;
        prev_wdata  = tail_sel;
        lvl_we      = 1'b0;
        lvl_wdata   = lvl_sel;
        head_next   = head_reg;
        tail_next   = tail_reg;
        count_next  = count_reg;
        queued_next = queued_reg;
        total_next  = total_reg;
        if (do_append) begin
            lvl_we = 1'b1;
            if (count_sel == '0) begin
                head_next[lvl_sel] = t_idx;
            end else begin
                next_we = 1'b1;
                prev_we = 1'b1;
            end
            tail_next[lvl_sel]  = t_idx;
            count_next[lvl_sel] = count_sel + CNT_W'(1);
        end
        if (do_unlink) begin
            if (is_head) begin
                head_next[lvl_sel] = next_rd;
            end else begin
                next_we    = 1'b1;
                next_waddr = prev_rd;
                next_wdata = next_rd;
            end
            if (is_tail) begin
                tail_next[lvl_sel] = prev_rd;
            end else begin
                prev_we    = 1'b1;
                prev_waddr = next_rd;
                prev_wdata = prev_rd;
            end
            if (count_sel != '0) begin
                count_next[lvl_sel] = count_sel - CNT_W'(1);
            end
        end
        if (ctrl.exec && cmd_reg == CMD_ENQ && enq_ok) begin
            queued_next[t_idx] = 1'b1;
            total_next         = total_reg + CNT_W'(1);
        end
        if (ctrl.exec && cmd_reg == CMD_DEQ && deq_ok) begin
            queued_next[t_idx] = 1'b0;
            total_next         = total_reg - CNT_W'(1);
        end
    end

    always_comb begin
        res_next              = res_reg;
        if (ctrl.exec) begin
            res_next              = '0;
            res_next.total_queued = TOTAL_W'(total_next);
            case (cmd_reg)
                CMD_ENQ: begin
                    res_next.status = !enq_ok;
                end
                CMD_DEQ: begin
                    res_next.status = !deq_ok;
                    if (deq_ok) begin
                        res_next.level_out = LVLO_W'(lvl_rd);
                    end
                end
                CMD_PICK: begin
                    res_next.status = !any_ne;
                    if (any_ne) begin
                        res_next.picked_task = TID_W'(head_sel);
                        res_next.pick_valid  = 1'b1;
                        res_next.level_out   = LVLO_W'(h);
                    end
                end
                CMD_TICK: begin
                    res_next.status  = !deq_ok;
                    res_next.resched = age;
                end
                default: begin
                    res_next.status = 1'b1;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            thr_reg     <= AGING_RESET;
            queued_reg  <= '0;
            total_reg   <= '0;
            m_valid_reg <= 1'b0;
            for (int i = 0; i < NUM_LEVELS; i++) begin
                count_reg[i] <= '0;
            end
        end else begin
            if (cfg_we) begin
                thr_reg <= cfg_wdata;
            end
            queued_reg <= queued_next;
            total_reg  <= total_next;
            count_reg  <= count_next;
            if (ctrl.resp && stat.out_free) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (ctrl.load) begin
            cmd_reg  <= cmd_t'(in_cmd);
            tid_reg  <= in_tid;
            preq_reg <= in_preq;
            time_reg <= in_time;
        end
        head_reg <= head_next;
        tail_reg <= tail_next;
        res_reg  <= res_next;
        if (ctrl.resp && stat.out_free) begin
            m_data_reg <= res_reg;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {{(M_DATA_W - $bits(result_t)){1'b0}}, m_data_reg};

endmodule

@@ rtl/priority_run_queue_with_aging.sv @@
// Top level of the priority run queue with aging: controller, datapath, assertions.
// Depends on prqa_pkg, prqa_ctrl, prqa_dp and the assertion macro header.
//
//  channel  dir  fields (lsb first)
//  s_       in   tuser: command; tdata: task_id, priority_req, exec_time
//  m_       out  tdata: status, picked_task, pick_valid, level_out, resched, total_queued
//  cfg_     in   cfg_wdata: aging_threshold
//
// Items are taken one at a time: accept, execute, respond; a tick that ages its
// task adds an append step, the second link RAM write pass for the append.
// Link RAM reads are registered, which puts the execute step in the cycle after accept.
// Reset is synchronous and needs no clearing pass; a stalled result holds the
// sequencer in its respond step and no new item is taken until it moves out.
`include "priority_run_queue_with_aging_assert.svh"

module priority_run_queue_with_aging import prqa_pkg::*; #(
    parameter int MAX_TASKS  = MAX_TASKS_DEF,
    parameter int NUM_LEVELS = NUM_LEVELS_DEF
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [S_DATA_W-1:0] s_tdata,   // task_id, priority_req, exec_time
    input  logic [CMD_W-1:0]    s_tuser,   // command
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [M_DATA_W-1:0] m_tdata,   // status, picked_task, pick_valid,
                                           // level_out, resched, total_queued
    input  logic                cfg_we,
    input  logic [TIME_W-1:0]   cfg_wdata
);

    ctrl_cmd_t ctrl;
    dp_stat_t  stat;

    prqa_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .ctrl     (ctrl)
    );

    prqa_dp #(
        .MAX_TASKS  (MAX_TASKS),
        .NUM_LEVELS (NUM_LEVELS)
    ) u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .ctrl      (ctrl),
        .stat      (stat),
        .in_cmd    (s_tuser),
        .in_tid    (s_tdata[TID_LSB +: TID_W]),
        .in_preq   (s_tdata[PRIO_LSB +: PRIO_W]),
        .in_time   (s_tdata[TIME_LSB +: TIME_W]),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .m_tready  (m_tready),
        .m_tvalid  (m_tvalid),
        .m_tdata   (m_tdata)
    );

    `PRQA_ASSERT_NEXT(a_busy_after_accept, aclk, aresetn, s_tvalid && s_tready, !s_tready, "item accepted while busy")
    `PRQA_ASSERT_NEXT(a_age_append, aclk, aresetn, ctrl.exec && stat.age, ctrl.append, "aging append skipped")
    `PRQA_ASSERT_NOW(a_result_source, aclk, aresetn, $rose(m_tvalid), $past(ctrl.resp), "result without respond step")
    `PRQA_ASSERT_NOW(a_pick_status, aclk, aresetn, m_tvalid && m_tdata[7], !m_tdata[0] && !m_tdata[11], "pick result inconsistent")

endmodule
